// File: design/tlpt_pkg.sv
// ============================================================================
// tlpt_pkg
// Types and constants shared by the two-level page table manager modules.
// ============================================================================
package tlpt_pkg;

    localparam int IDX_W    = 10;   // directory / table index field width
    localparam int VPAGE_W  = 20;
    localparam int OFFSET_W = 12;
    localparam int FRAME_W  = 20;
    localparam int ADDR_W   = 32;
    localparam int PE_W     = 25;   // page entry: frame[24:5], pcd, pwt, user, rw, present

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_UNMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_RSV   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOMEM   = 2'd1,
        STS_EXISTS  = 2'd2,
        STS_MISSING = 2'd3
    } status_code_t;

    typedef enum logic [2:0] {
        S_CLR_DIR,
        S_IDLE,
        S_LOOKUP,
        S_ENTRY,
        S_CLR_TAB
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic         ready;
        logic         capture;
        logic         dir_clr;
        logic         alloc;
        logic         pe_rd;
        logic         clr_step;
        logic         pe_wr_new;
        logic         pe_wr_zero;
        logic         fin;
        logic         fin_addr;
        status_code_t fin_status;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dir_clr_last;
        logic clr_last;
        logic idx_ok;
        op_t  op;
        logic dir_present;
        logic slots_full;
        logic pe_present;
        logic force_req;
        logic out_free;
    } dp_sts_t;

endpackage

// File: design/tlpt_ram.sv
// ============================================================================
// tlpt_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/tlpt_ctrl.sv
// ============================================================================
// tlpt_ctrl
// Sequencer for the page table manager: clear pass, lookup, entry update,
// table clear on slot allocation and result hand-off.
// ============================================================================
module tlpt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tlpt_pkg::dp_sts_t   sts,
    output tlpt_pkg::ctrl_cmd_t cmd
);

    tlpt_pkg::state_t state_reg;
    tlpt_pkg::state_t state_next;

    logic op_map;
    logic op_unmap;
    logic bad_req;
    logic need_alloc;

    assign op_map     = (sts.op == tlpt_pkg::OP_MAP);
    assign op_unmap   = (sts.op == tlpt_pkg::OP_UNMAP);
    assign bad_req    = !sts.idx_ok || (sts.op == tlpt_pkg::OP_RSV);
    assign need_alloc = op_map && !sts.dir_present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlpt_pkg::S_CLR_DIR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlpt_pkg::S_CLR_DIR:
            begin
                if (sts.dir_clr_last)
                begin
                    state_next = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tlpt_pkg::S_LOOKUP;
                end
            end
            tlpt_pkg::S_LOOKUP:
            begin
                priority if (bad_req)
                begin
                    if (sts.out_free)
                    begin
                        state_next = tlpt_pkg::S_IDLE;
                    end
                end
                else if (need_alloc)
                begin
                    if (!sts.slots_full)
                    begin
                        state_next = tlpt_pkg::S_CLR_TAB;
                    end
                    else if (sts.out_free)
                    begin
                        state_next = tlpt_pkg::S_IDLE;
                    end
                end
                else if (sts.dir_present)
                begin
                    state_next = tlpt_pkg::S_ENTRY;
                end
                else if (sts.out_free)
                begin
                    state_next = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_ENTRY:
            begin
                if (sts.out_free)
                begin
                    state_next = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_CLR_TAB:
            begin
                if (sts.clr_last && sts.out_free)
                begin
                    state_next = tlpt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlpt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.fin_status = tlpt_pkg::STS_MISSING;
        cmd.ready      = (state_reg == tlpt_pkg::S_IDLE);
        cmd.capture    = cmd.ready && in_valid;
        unique case (state_reg)
            tlpt_pkg::S_CLR_DIR:
            begin
                cmd.dir_clr = 1'b1;
            end
            tlpt_pkg::S_IDLE:
            begin
            end
            tlpt_pkg::S_LOOKUP:
            begin
                priority if (bad_req)
                begin
                    cmd.fin = sts.out_free;
                end
                else if (need_alloc)
                begin
                    if (sts.slots_full)
                    begin
                        cmd.fin        = sts.out_free;
                        cmd.fin_status = tlpt_pkg::STS_NOMEM;
                    end
                    else
                    begin
                        cmd.alloc = 1'b1;
                    end
                end
                else if (sts.dir_present)
                begin
                    cmd.pe_rd = 1'b1;
                end
                else
                begin
                    cmd.fin = sts.out_free;
                end
            end
            tlpt_pkg::S_ENTRY:
            begin
                cmd.fin = sts.out_free;
                priority if (op_map)
                begin
                    if (sts.pe_present && !sts.force_req)
                    begin
                        cmd.fin_status = tlpt_pkg::STS_EXISTS;
                    end
                    else
                    begin
                        cmd.fin_status = tlpt_pkg::STS_OK;
                        cmd.pe_wr_new  = sts.out_free;
                    end
                end
                else if (op_unmap)
                begin
                    if (sts.pe_present)
                    begin
                        cmd.fin_status = tlpt_pkg::STS_OK;
                        cmd.pe_wr_zero = sts.out_free;
                    end
                end
                else
                begin
                    if (sts.pe_present)
                    begin
                        cmd.fin_status = tlpt_pkg::STS_OK;
                        cmd.fin_addr   = 1'b1;
                    end
                end
            end
            tlpt_pkg::S_CLR_TAB:
            begin
                // the new entry is written in place during the clear sweep
                cmd.clr_step   = !sts.clr_last || sts.out_free;
                cmd.fin        = sts.clr_last && sts.out_free;
                cmd.fin_status = tlpt_pkg::STS_OK;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: design/tlpt_dp.sv
// ============================================================================
// tlpt_dp
// Datapath: request registers, directory and page entry RAMs, slot counter,
// sweep counter and the result register.
// ============================================================================
module tlpt_dp #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_SLOTS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlpt_pkg::ctrl_cmd_t               cmd,
    output tlpt_pkg::dp_sts_t                 sts,
    input  logic [1:0]                        in_cmd,
    input  logic [tlpt_pkg::VPAGE_W-1:0]      virt_page,
    input  logic [tlpt_pkg::OFFSET_W-1:0]     page_offset,
    input  logic [tlpt_pkg::FRAME_W-1:0]      phys_frame,
    input  logic                              force_req,
    input  logic                              kernel_only,
    input  logic                              writable,
    input  logic                              write_thru,
    input  logic                              cache_disable,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [tlpt_pkg::ADDR_W-1:0]       phys_addr
);

    localparam int DIR_W    = $clog2(DIR_ENTRIES);
    localparam int TAB_W    = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int USED_W   = $clog2(TABLE_SLOTS + 1);
    localparam int CNT_MAX  = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
    localparam int CNT_W    = $clog2(CNT_MAX);
    localparam int DIR_DW   = SLOT_W + 1;
    localparam int PE_DEPTH = TABLE_SLOTS * (2 ** TAB_W);
    localparam int PE_AW    = $clog2(PE_DEPTH);
    localparam int IDX_W    = tlpt_pkg::IDX_W;

    // request registers
    tlpt_pkg::op_t                   op_reg;
    logic [IDX_W-1:0]                dix_reg;
    logic [IDX_W-1:0]                tix_reg;
    logic [tlpt_pkg::OFFSET_W-1:0]   offset_reg;
    logic [tlpt_pkg::FRAME_W-1:0]    frame_reg;
    logic                            force_reg;
    logic                            kern_reg;
    logic                            rw_reg;
    logic                            pwt_reg;
    logic                            pcd_reg;

    logic [CNT_W-1:0]                cnt_reg;
    logic [CNT_W-1:0]                cnt_next;
    logic [USED_W-1:0]               used_reg;
    logic [USED_W-1:0]               used_next;
    logic [SLOT_W-1:0]               slot_reg;
    logic [SLOT_W-1:0]               slot_next;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    tlpt_pkg::status_code_t          status_reg;
    logic [tlpt_pkg::ADDR_W-1:0]     addr_reg;

    logic                            dir_wr_en;
    logic [DIR_W-1:0]                dir_wr_addr;
    logic [DIR_DW-1:0]               dir_wr_data;
    logic [DIR_DW-1:0]               dir_rd_data;
    logic [SLOT_W-1:0]               dir_rd_slot;

    logic                            pe_wr_en;
    logic [SLOT_W+TAB_W-1:0]         pe_wr_full;
    logic [SLOT_W+TAB_W-1:0]         pe_rd_full;
    logic [tlpt_pkg::PE_W-1:0]       pe_wr_data;
    logic [tlpt_pkg::PE_W-1:0]       pe_rd_data;
    logic [tlpt_pkg::PE_W-1:0]       new_entry;
    logic [TAB_W-1:0]                pe_idx;
    logic                            clr_hit;

    logic                            dir_last;
    logic                            tab_last;

    assign dir_last = (cnt_reg == CNT_W'(DIR_ENTRIES - 1));
    assign tab_last = (cnt_reg == CNT_W'(TABLE_ENTRIES - 1));

    // bit 0 present, 1 rw, 2 user, 3 write-through, 4 cache-disable, 24..5 frame
    assign new_entry = {frame_reg, pcd_reg, pwt_reg, !kern_reg, rw_reg, 1'b1};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= tlpt_pkg::op_t'(in_cmd);
            dix_reg    <= virt_page[tlpt_pkg::VPAGE_W-1:IDX_W];
            tix_reg    <= virt_page[IDX_W-1:0];
            offset_reg <= page_offset;
            frame_reg  <= phys_frame;
            force_reg  <= force_req;
            kern_reg   <= kernel_only;
            rw_reg     <= writable;
            pwt_reg    <= write_thru;
            pcd_reg    <= cache_disable;
        end
    end

    // sweep counter, shared by the reset pass and the table clear
    always_comb
    begin
        cnt_next = cnt_reg;
        priority if (cmd.dir_clr)
        begin
            cnt_next = dir_last ? '0 : cnt_reg + CNT_W'(1);
        end
        else if (cmd.clr_step)
        begin
            cnt_next = tab_last ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        used_next = used_reg;
        slot_next = slot_reg;
        priority if (cmd.alloc)
        begin
            used_next = used_reg + USED_W'(1);
            slot_next = used_reg[SLOT_W-1:0];
        end
        else if (cmd.pe_rd)
        begin
            slot_next = dir_rd_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            used_reg <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // directory RAM: {present, slot}
    assign dir_wr_en   = cmd.dir_clr || cmd.alloc;
    assign dir_wr_addr = cmd.dir_clr ? cnt_reg[DIR_W-1:0] : dix_reg[DIR_W-1:0];
    assign dir_wr_data = cmd.dir_clr ? '0 : {1'b1, used_reg[SLOT_W-1:0]};
    assign dir_rd_slot = dir_rd_data[SLOT_W-1:0];

    tlpt_ram #(
        .WIDTH (DIR_DW),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk     (clk),
        .wr_en   (dir_wr_en),
        .wr_addr (dir_wr_addr),
        .wr_data (dir_wr_data),
        .rd_en   (cmd.capture),
        .rd_addr (virt_page[IDX_W +: DIR_W]),
        .rd_data (dir_rd_data)
    );

    // page entry RAM, addressed {slot, table index}
    assign clr_hit    = (cnt_reg[TAB_W-1:0] == tix_reg[TAB_W-1:0]);
    assign pe_idx     = cmd.clr_step ? cnt_reg[TAB_W-1:0] : tix_reg[TAB_W-1:0];
    assign pe_wr_en   = cmd.clr_step || cmd.pe_wr_new || cmd.pe_wr_zero;
    assign pe_wr_full = {slot_reg, pe_idx};
    assign pe_rd_full = {dir_rd_slot, tix_reg[TAB_W-1:0]};
    assign pe_wr_data = (cmd.pe_wr_zero || (cmd.clr_step && !clr_hit)) ? '0 : new_entry;

    tlpt_ram #(
        .WIDTH (tlpt_pkg::PE_W),
        .DEPTH (PE_DEPTH)
    ) u_pe_ram (
        .clk     (clk),
        .wr_en   (pe_wr_en),
        .wr_addr (pe_wr_full[PE_AW-1:0]),
        .wr_data (pe_wr_data),
        .rd_en   (cmd.pe_rd),
        .rd_addr (pe_rd_full[PE_AW-1:0]),
        .rd_data (pe_rd_data)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            status_reg <= cmd.fin_status;
            addr_reg   <= cmd.fin_addr ?
                          {pe_rd_data[tlpt_pkg::PE_W-1:5], offset_reg} : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign phys_addr = addr_reg;

    assign sts.dir_clr_last = dir_last;
    assign sts.clr_last     = tab_last;
    assign sts.idx_ok       = ({1'b0, dix_reg} < (IDX_W + 1)'(DIR_ENTRIES)) &&
                              ({1'b0, tix_reg} < (IDX_W + 1)'(TABLE_ENTRIES));
    assign sts.op           = op_reg;
    assign sts.dir_present  = dir_rd_data[SLOT_W];
    assign sts.slots_full   = (used_reg == USED_W'(TABLE_SLOTS));
    assign sts.pe_present   = pe_rd_data[0];
    assign sts.force_req    = force_reg;
    assign sts.out_free     = !out_valid_reg || !out_stall;

endmodule

// File: design/two_level_page_table_manager_top.sv
// ============================================================================
// two_level_page_table_manager_top
// Two-level page table: map, unmap and translate on a 4 KiB page scheme.
// ============================================================================
// One item at a time. After reset the directory RAM is swept clear, one entry
// per cycle, and no item is taken until that is done. A result is loaded
// after the registered directory read and the registered page entry read,
// with the update done as the result loads. The next item can be taken the
// cycle after the result loads. A reserved command, an index out of range or
// a missing directory entry answers after the directory read alone. A map
// that needs a fresh table slot instead sweeps that slot's table, writing the
// new entry in place, and loads its result as the sweep writes its last entry.
// Results sit in an output register; while a stalled result still holds it,
// the next item waits at its last step.
module two_level_page_table_manager_top #(
    parameter int DIR_ENTRIES   = 1024,
    parameter int TABLE_ENTRIES = 1024,
    parameter int TABLE_SLOTS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [tlpt_pkg::VPAGE_W-1:0]  virt_page,
    input  logic [tlpt_pkg::OFFSET_W-1:0] page_offset,
    input  logic [tlpt_pkg::FRAME_W-1:0]  phys_frame,
    input  logic                          force_req,
    input  logic                          kernel_only,
    input  logic                          writable,
    input  logic                          write_thru,
    input  logic                          cache_disable,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [tlpt_pkg::ADDR_W-1:0]   phys_addr
);

    tlpt_pkg::ctrl_cmd_t ctrl_cmd;
    tlpt_pkg::dp_sts_t   dp_sts;

    assign in_stall = !ctrl_cmd.ready;

    tlpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    tlpt_dp #(
        .DIR_ENTRIES   (DIR_ENTRIES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .TABLE_SLOTS   (TABLE_SLOTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .sts           (dp_sts),
        .in_cmd        (cmd),
        .virt_page     (virt_page),
        .page_offset   (page_offset),
        .phys_frame    (phys_frame),
        .force_req     (force_req),
        .kernel_only   (kernel_only),
        .writable      (writable),
        .write_thru    (write_thru),
        .cache_disable (cache_disable),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .phys_addr     (phys_addr)
    );

`ifndef SYNTHESIS
    a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.fin |-> dp_sts.out_free)
        else $error("result loaded while output register busy");

    a_alloc_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.alloc |-> !dp_sts.slots_full)
        else $error("slot allocated with none left");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl_cmd.fin))
        else $error("result appeared without a finish");

    a_one_pe_write: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_cmd.pe_wr_new |-> !ctrl_cmd.pe_wr_zero && !ctrl_cmd.clr_step)
        else $error("conflicting page entry writes");
`endif

endmodule
